>>> hdl/quat_scale_to_covariance_top_assert.svh
// Assertion macros shared by the covariance block.
`ifndef QUAT_SCALE_TO_COVARIANCE_TOP_ASSERT_SVH
`define QUAT_SCALE_TO_COVARIANCE_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define QSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define QSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/qsc_pkg.sv
// Types and constants of the quaternion/scale to covariance block.
package qsc_pkg;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_ZERO_QUAT  = 2'd1;
  localparam logic [1:0] ERR_ZERO_SCALE = 2'd2;

  localparam logic KIND_COV  = 1'b0;
  localparam logic KIND_PREC = 1'b1;

  localparam logic [1:0] CFG_EMIT_COV   = 2'd0;
  localparam logic [1:0] CFG_EMIT_PREC  = 2'd1;
  localparam logic [1:0] CFG_UPPER_ONLY = 2'd2;

  // Rotation divider: 32 quotient bits, 2 per stage.
  localparam int ROT_N_W   = 64;
  localparam int ROT_D_W   = 33;
  localparam int ROT_Q_W   = 32;
  localparam int ROT_STEPS = 2;
  // Inverse weight divider: 64 quotient bits, 4 per stage.
  localparam int WT_N_W    = 65;
  localparam int WT_D_W    = 48;
  localparam int WT_Q_W    = 64;
  localparam int WT_STEPS  = 4;
  localparam int DIV_STAGES = ROT_Q_W / ROT_STEPS;

  localparam int SQ_W  = 48;
  localparam int ACC_W = 128;

  // Upper entries in port order: 00 01 02 11 12 22.
  localparam int NUM_UP = 6;
  localparam int ENT_ROW [NUM_UP] = '{0, 0, 0, 1, 1, 2};
  localparam int ENT_COL [NUM_UP] = '{0, 1, 2, 1, 2, 2};
  // Lower entries 10 20 21 mirror upper entries 01 02 12.
  localparam int LOW_SRC [3] = '{1, 2, 4};

  typedef struct packed {
    logic       kind;
    logic       last;
    logic [1:0] err;
  } tag_t;

endpackage

>>> hdl/quat_scale_to_covariance_top.sv
// Pipeline: 24 register stages (two front stages, 16 divider stages, six multiply/sum/saturate
// stages incl. the output register); every stage holds while out_valid and out_stall are high.
// Throughput: one result per cycle while the output is not stalled; an item with two results
// holds the input for its covariance half, set by the single result slot the front takes per cycle.
// Reset: registers return to covariance only, full matrix; pipeline valids clear.
module quat_scale_to_covariance_top import qsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic        [23:0] in_scale_x,
  input  logic        [23:0] in_scale_y,
  input  logic        [23:0] in_scale_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_matrix_kind,
  output logic               out_last_of_item,
  output logic        [1:0]  out_error_code,
  output logic signed [63:0] out_entry_00,
  output logic signed [63:0] out_entry_01,
  output logic signed [63:0] out_entry_02,
  output logic signed [63:0] out_entry_11,
  output logic signed [63:0] out_entry_12,
  output logic signed [63:0] out_entry_22,
  output logic signed [63:0] out_entry_10,
  output logic signed [63:0] out_entry_20,
  output logic signed [63:0] out_entry_21,
  input  logic               cfg_wr_en,
  input  logic        [1:0]  cfg_index,
  input  logic        [0:0]  cfg_data
);

  `include "quat_scale_to_covariance_top_assert.svh"

  // Configuration
  logic emit_cov_r, emit_prec_r, upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cov_r  <= 1'b1;
      emit_prec_r <= 1'b0;
      upper_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_EMIT_COV:   emit_cov_r  <= cfg_data[0];
        CFG_EMIT_PREC:  emit_prec_r <= cfg_data[0];
        CFG_UPPER_ONLY: upper_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: classify the item and expand it into zero, one or two result slots
  logic en, out_valid_r, phase_r;
  logic zq, zs, err_s, two, none, slot_v;
  tag_t slot_tag;

  assign en = !(out_valid_r && out_stall);

  always_comb begin
    zq    = (in_quat_w == 16'sd0) && (in_quat_x == 16'sd0) &&
            (in_quat_y == 16'sd0) && (in_quat_z == 16'sd0);
    zs    = (in_scale_x == 24'd0) || (in_scale_y == 24'd0) || (in_scale_z == 24'd0);
    err_s = !zq && emit_prec_r && zs;
    two   = !zq && !err_s && emit_cov_r && emit_prec_r;
    none  = !zq && !err_s && !emit_cov_r && !emit_prec_r;
    slot_v = in_valid && !none;
    if (zq) begin
      slot_tag = '{kind: KIND_COV, last: 1'b1, err: ERR_ZERO_QUAT};
    end else if (err_s) begin
      slot_tag = '{kind: KIND_PREC, last: 1'b1, err: ERR_ZERO_SCALE};
    end else if (two) begin
      slot_tag = '{kind: phase_r, last: phase_r, err: ERR_NONE};
    end else begin
      slot_tag = '{kind: emit_prec_r, last: 1'b1, err: ERR_NONE};
    end
  end

  // hold the input during the covariance half of a two-result item
  assign in_stall = !en || (two && !phase_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (en) begin
      phase_r <= in_valid && two && !phase_r;
    end
  end

  // Stage 1: component products and squared scales
  logic v1_r;
  tag_t tag1_r;
  logic signed [31:0] ww1_r, xx1_r, yy1_r, zz1_r, xy1_r, wz1_r, xz1_r, wy1_r, yz1_r, wx1_r;
  logic [SQ_W-1:0] sq1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r   <= slot_tag;
      ww1_r    <= in_quat_w * in_quat_w;
      xx1_r    <= in_quat_x * in_quat_x;
      yy1_r    <= in_quat_y * in_quat_y;
      zz1_r    <= in_quat_z * in_quat_z;
      xy1_r    <= in_quat_x * in_quat_y;
      wz1_r    <= in_quat_w * in_quat_z;
      xz1_r    <= in_quat_x * in_quat_z;
      wy1_r    <= in_quat_w * in_quat_y;
      yz1_r    <= in_quat_y * in_quat_z;
      wx1_r    <= in_quat_w * in_quat_x;
      sq1_r[0] <= SQ_W'(in_scale_x) * SQ_W'(in_scale_x);
      sq1_r[1] <= SQ_W'(in_scale_y) * SQ_W'(in_scale_y);
      sq1_r[2] <= SQ_W'(in_scale_z) * SQ_W'(in_scale_z);
    end
  end

  // Stage 2: squared norm, rotation numerators, divider operands
  logic v2_r;
  tag_t tag2_r;
  logic [ROT_N_W-1:0] dvd2_r [9];
  logic [ROT_D_W-1:0] den2_r;
  logic [8:0]         sgn2_r;
  logic [WT_N_W-1:0]  wdvd2_r [3];
  logic [SQ_W-1:0]    sq2_r [3];

  logic [ROT_D_W-1:0] n2;
  logic signed [34:0] num [9];
  logic [ROT_D_W-1:0] mag [9];

  always_comb begin
    logic signed [34:0] eww, exx, eyy, ezz, exy, ewz, exz, ewy, eyz, ewx;
    eww = 35'(ww1_r); exx = 35'(xx1_r); eyy = 35'(yy1_r); ezz = 35'(zz1_r);
    exy = 35'(xy1_r); ewz = 35'(wz1_r); exz = 35'(xz1_r); ewy = 35'(wy1_r);
    eyz = 35'(yz1_r); ewx = 35'(wx1_r);
    n2 = ROT_D_W'($unsigned(ww1_r)) + ROT_D_W'($unsigned(xx1_r)) +
         ROT_D_W'($unsigned(yy1_r)) + ROT_D_W'($unsigned(zz1_r));
    num[0] = eww + exx - eyy - ezz;
    num[1] = (exy - ewz) <<< 1;
    num[2] = (exz + ewy) <<< 1;
    num[3] = (exy + ewz) <<< 1;
    num[4] = eww - exx + eyy - ezz;
    num[5] = (eyz - ewx) <<< 1;
    num[6] = (exz - ewy) <<< 1;
    num[7] = (eyz + ewx) <<< 1;
    num[8] = eww - exx - eyy + ezz;
    for (int i = 0; i < 9; i++) begin
      mag[i] = num[i][34] ? ROT_D_W'(-num[i]) : ROT_D_W'(num[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r <= tag1_r;
      den2_r <= n2;
      for (int i = 0; i < 9; i++) begin
        dvd2_r[i] <= (ROT_N_W'(mag[i]) << 30) + ROT_N_W'(n2 >> 1);
        sgn2_r[i] <= num[i][34];
      end
      for (int k = 0; k < 3; k++) begin
        wdvd2_r[k] <= {1'b1, 64'(sq1_r[k] >> 1)};
        sq2_r[k]   <= sq1_r[k];
      end
    end
  end

  // Dividers: rotation entries and inverse squared scales
  logic [ROT_D_W-1:0] rot_den [9];
  logic [ROT_Q_W-1:0] rot_q   [9];
  logic [WT_Q_W-1:0]  wt_q    [3];

  always_comb begin
    for (int i = 0; i < 9; i++) rot_den[i] = den2_r;
  end

  qsc_div #(
    .LANES(9), .N_W(ROT_N_W), .D_W(ROT_D_W), .Q_W(ROT_Q_W), .STEPS(ROT_STEPS)
  ) u_rot_div (
    .clk(clk), .en(en), .num_i(dvd2_r), .den_i(rot_den), .quo_o(rot_q)
  );

  qsc_div #(
    .LANES(3), .N_W(WT_N_W), .D_W(WT_D_W), .Q_W(WT_Q_W), .STEPS(WT_STEPS)
  ) u_wt_div (
    .clk(clk), .en(en), .num_i(wdvd2_r), .den_i(sq2_r), .quo_o(wt_q)
  );

  // Side data travels alongside the divider stages
  logic            dv_r   [DIV_STAGES];
  tag_t            dtag_r [DIV_STAGES];
  logic [8:0]      dsgn_r [DIV_STAGES];
  logic [SQ_W-1:0] dsq_r  [DIV_STAGES][3];

  always_ff @(posedge clk) begin
    if (en) begin
      dtag_r[0] <= tag2_r;
      dsgn_r[0] <= sgn2_r;
      dsq_r[0]  <= sq2_r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dtag_r[s] <= dtag_r[s-1];
        dsgn_r[s] <= dsgn_r[s-1];
        dsq_r[s]  <= dsq_r[s-1];
      end
    end
  end

  // Stage 4: rotation products and per-axis weights
  localparam int LD = DIV_STAGES - 1;
  logic v4_r;
  tag_t tag4_r;
  logic [61:0] pm4_r [NUM_UP][3];
  logic        ps4_r [NUM_UP][3];
  logic [63:0] wt4_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      tag4_r <= dtag_r[LD];
      for (int k = 0; k < 3; k++) begin
        if (dtag_r[LD].kind == KIND_PREC) begin
          wt4_r[k] <= (dsq_r[LD][k] == SQ_W'(1)) ? '1 : wt_q[k];
        end else begin
          wt4_r[k] <= 64'(dsq_r[LD][k]);
        end
      end
      for (int e = 0; e < NUM_UP; e++) begin
        for (int k = 0; k < 3; k++) begin
          pm4_r[e][k] <= 62'(rot_q[ENT_ROW[e]*3+k][30:0]) *
                         62'(rot_q[ENT_COL[e]*3+k][30:0]);
          ps4_r[e][k] <= dsgn_r[LD][ENT_ROW[e]*3+k] ^ dsgn_r[LD][ENT_COL[e]*3+k];
        end
      end
    end
  end

  // Stage 5: 32x32 partial products of each weighted term
  logic v5_r;
  tag_t tag5_r;
  logic [63:0] pp5_r [NUM_UP][3][4];
  logic        ps5_r [NUM_UP][3];

  always_ff @(posedge clk) begin
    if (en) begin
      tag5_r <= tag4_r;
      ps5_r  <= ps4_r;
      for (int e = 0; e < NUM_UP; e++) begin
        for (int k = 0; k < 3; k++) begin
          pp5_r[e][k][0] <= 64'(pm4_r[e][k][31:0])  * 64'(wt4_r[k][31:0]);
          pp5_r[e][k][1] <= 64'(pm4_r[e][k][31:0])  * 64'(wt4_r[k][63:32]);
          pp5_r[e][k][2] <= 64'(pm4_r[e][k][61:32]) * 64'(wt4_r[k][31:0]);
          pp5_r[e][k][3] <= 64'(pm4_r[e][k][61:32]) * 64'(wt4_r[k][63:32]);
        end
      end
    end
  end

  // Stage 6: term magnitudes
  logic v6_r;
  tag_t tag6_r;
  logic [ACC_W-1:0] mag6_r [NUM_UP][3];
  logic             ps6_r  [NUM_UP][3];

  always_ff @(posedge clk) begin
    if (en) begin
      tag6_r <= tag5_r;
      ps6_r  <= ps5_r;
      for (int e = 0; e < NUM_UP; e++) begin
        for (int k = 0; k < 3; k++) begin
          mag6_r[e][k] <= ACC_W'(pp5_r[e][k][0]) +
                          (ACC_W'(pp5_r[e][k][1]) << 32) +
                          (ACC_W'(pp5_r[e][k][2]) << 32) +
                          (ACC_W'(pp5_r[e][k][3]) << 64);
        end
      end
    end
  end

  // Stage 7: apply signs
  logic v7_r;
  tag_t tag7_r;
  logic [ACC_W-1:0] trm7_r [NUM_UP][3];

  always_ff @(posedge clk) begin
    if (en) begin
      tag7_r <= tag6_r;
      for (int e = 0; e < NUM_UP; e++) begin
        for (int k = 0; k < 3; k++) begin
          trm7_r[e][k] <= ps6_r[e][k] ? (ACC_W'(0) - mag6_r[e][k]) : mag6_r[e][k];
        end
      end
    end
  end

  // Stage 8: sum three terms plus rounding half
  logic v8_r;
  tag_t tag8_r;
  logic [ACC_W-1:0] acc8_r [NUM_UP];

  always_ff @(posedge clk) begin
    if (en) begin
      tag8_r <= tag7_r;
      for (int e = 0; e < NUM_UP; e++) begin
        acc8_r[e] <= trm7_r[e][0] + trm7_r[e][1] + trm7_r[e][2] + (ACC_W'(1) << 59);
      end
    end
  end

  // Output register: shift, saturate, zero all entries on error and the lower entries in upper mode
  tag_t out_tag_r;
  logic [63:0] ent_r [9];
  logic [63:0] sat [NUM_UP];

  always_comb begin
    logic signed [ACC_W-1:0] sh;
    for (int e = 0; e < NUM_UP; e++) begin
      sh = $signed(acc8_r[e]) >>> 60;
      if (sh[ACC_W-1:63] == {(ACC_W-63){sh[63]}}) begin
        sat[e] = sh[63:0];
      end else begin
        sat[e] = sh[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag_r <= tag8_r;
      for (int e = 0; e < NUM_UP; e++) begin
        ent_r[e] <= (tag8_r.err != ERR_NONE) ? 64'd0 : sat[e];
      end
      for (int j = 0; j < 3; j++) begin
        ent_r[NUM_UP+j] <= ((tag8_r.err != ERR_NONE) || upper_r) ? 64'd0 : sat[LOW_SRC[j]];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; out_valid_r <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) dv_r[s] <= 1'b0;
    end else if (en) begin
      v1_r  <= slot_v;
      v2_r  <= v1_r;
      dv_r[0] <= v2_r;
      for (int s = 1; s < DIV_STAGES; s++) dv_r[s] <= dv_r[s-1];
      v4_r  <= dv_r[LD];
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matrix_kind  = out_tag_r.kind;
  assign out_last_of_item = out_tag_r.last;
  assign out_error_code   = out_tag_r.err;
  assign out_entry_00     = ent_r[0];
  assign out_entry_01     = ent_r[1];
  assign out_entry_02     = ent_r[2];
  assign out_entry_11     = ent_r[3];
  assign out_entry_12     = ent_r[4];
  assign out_entry_22     = ent_r[5];
  assign out_entry_10     = ent_r[6];
  assign out_entry_20     = ent_r[7];
  assign out_entry_21     = ent_r[8];

  `QSC_ASSERT_IMP(a_err_zero, out_valid_r && (out_tag_r.err != ERR_NONE), out_tag_r.last && ent_r[0] == 64'd0 && ent_r[6] == 64'd0, "error result not final or not zero")
  `QSC_ASSERT_IMP(a_first_is_cov, out_valid_r && !out_tag_r.last, out_tag_r.kind == KIND_COV && out_tag_r.err == ERR_NONE, "first of two results is not a clean covariance")
  `QSC_ASSERT_IMP(a_scale_err_prec, out_valid_r && out_tag_r.err == ERR_ZERO_SCALE, out_tag_r.kind == KIND_PREC, "zero-scale error not on precision")
  `QSC_ASSERT_IMP(a_lower_mirror, out_valid_r && ent_r[6] != 64'd0, ent_r[6] == ent_r[1], "lower entry differs from its mirror")
  `QSC_ASSERT_NXT(a_pair_phase, in_valid && !in_stall && phase_r, !phase_r, "phase not cleared after second transfer")

endmodule

>>> hdl/qsc_div.sv
// Pipelined restoring divider, several quotient bits per stage, many lanes.
module qsc_div #(
  parameter int LANES = 1,
  parameter int N_W   = 64,
  parameter int D_W   = 33,
  parameter int Q_W   = 32,
  parameter int STEPS = 2
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num_i [LANES],
  input  logic [D_W-1:0] den_i [LANES],
  output logic [Q_W-1:0] quo_o [LANES]
);

  localparam int NST = Q_W / STEPS;

  logic [D_W-1:0] rem_r   [NST][LANES];
  logic [Q_W-1:0] acc_r   [NST][LANES];
  logic [D_W-1:0] den_r   [NST][LANES];
  logic [D_W-1:0] rem_nxt [NST][LANES];
  logic [Q_W-1:0] acc_nxt [NST][LANES];
  logic [D_W-1:0] den_nxt [NST][LANES];

  // acc shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [D_W:0]   r;
    logic [D_W-1:0] rm;
    logic [D_W-1:0] dn;
    logic [Q_W-1:0] ac;
    for (int s = 0; s < NST; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          rm = D_W'(num_i[l] >> Q_W);
          ac = num_i[l][Q_W-1:0];
          dn = den_i[l];
        end else begin
          rm = rem_r[s-1][l];
          ac = acc_r[s-1][l];
          dn = den_r[s-1][l];
        end
        for (int k = 0; k < STEPS; k++) begin
          r  = {rm, ac[Q_W-1]};
          ac = {ac[Q_W-2:0], 1'b0};
          if (r >= {1'b0, dn}) begin
            r     = r - {1'b0, dn};
            ac[0] = 1'b1;
          end
          rm = r[D_W-1:0];
        end
        rem_nxt[s][l] = rm;
        acc_nxt[s][l] = ac;
        den_nxt[s][l] = dn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      den_r <= den_nxt;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) quo_o[l] = acc_r[NST-1][l];
  end

endmodule
